// ===== design/mmdds_pkg.sv =====
// Shared types, constants and the sine table for the multimode DDS tone generator.
// No dependencies; every module of the block imports this package.
package mmdds_pkg;

	localparam int TABLE_SIZE = 256;
	localparam int PAN_PERIOD = 48000;
	localparam int SAMPLE_HZ  = 48000;
	localparam int QUARTER    = TABLE_SIZE / 4;

	localparam int IDX_W    = $clog2(TABLE_SIZE);
	localparam int FRAC_W   = 16;
	localparam int PHASE_W  = IDX_W + FRAC_W;
	localparam int SAMPLE_W = 16;
	localparam int MIX_W    = SAMPLE_W + 2;
	localparam int WORD_W   = 31;
	localparam int WORD_LSB = 15;
	localparam int PAN_W    = $clog2(PAN_PERIOD + 1);

	localparam int MODE_W = 3;
	localparam int GAIN_W = 25;
	localparam int TONE_W = 23;
	localparam int CFG_AW = 2;
	localparam int CFG_DW = 25;

	localparam int CMD_DEPTH = 4;
	localparam int OUT_DEPTH = 8;

	localparam logic [CFG_AW-1:0] REG_MODE = CFG_AW'(0);
	localparam logic [CFG_AW-1:0] REG_GAIN = CFG_AW'(1);
	localparam logic [CFG_AW-1:0] REG_TONE = CFG_AW'(2);

	localparam logic [MODE_W-1:0] MODE_TONE   = MODE_W'(0);
	localparam logic [MODE_W-1:0] MODE_ALT    = MODE_W'(1);
	localparam logic [MODE_W-1:0] MODE_SWEEP  = MODE_W'(2);
	localparam logic [MODE_W-1:0] MODE_CHORD  = MODE_W'(3);
	localparam logic [MODE_W-1:0] MODE_SILENT = MODE_W'(4);

	localparam logic [PHASE_W-1:0] STEP_A4 =
		PHASE_W'(64'd44000 * TABLE_SIZE * 65536 / (64'(SAMPLE_HZ) * 100));
	localparam logic [PHASE_W-1:0] STEP_A5 =
		PHASE_W'(64'd88000 * TABLE_SIZE * 65536 / (64'(SAMPLE_HZ) * 100));
	localparam logic [PHASE_W-1:0] STEP_CS5 =
		PHASE_W'(64'd55437 * TABLE_SIZE * 65536 / (64'(SAMPLE_HZ) * 100));
	localparam logic [PHASE_W-1:0] STEP_E5 =
		PHASE_W'(64'd65925 * TABLE_SIZE * 65536 / (64'(SAMPLE_HZ) * 100));

	localparam logic [63:0] SWEEP_START_64 = ((64'd20 * TABLE_SIZE) << 32) / SAMPLE_HZ;
	localparam logic [63:0] SWEEP_LIMIT_64 = ((64'd20000 * TABLE_SIZE) << 32) / SAMPLE_HZ;
	localparam int SWEEP_W = $clog2(SWEEP_LIMIT_64) + 1;
	localparam logic [SWEEP_W-1:0] SWEEP_START = SWEEP_W'(SWEEP_START_64);
	localparam logic [SWEEP_W-1:0] SWEEP_LIMIT = SWEEP_W'(SWEEP_LIMIT_64);
	localparam int SWEEP_MUL   = 1258;
	localparam int SWEEP_MUL_W = $clog2(SWEEP_MUL + 1);
	localparam int SWEEP_SHIFT = 23;

	localparam int GAIN_FRAC = 24;
	localparam logic [GAIN_W-1:0] UNITY_GAIN = GAIN_W'(1) << GAIN_FRAC;

	localparam int DIV3_RECIP   = 43691;
	localparam int DIV3_RECIP_W = 16;
	localparam int DIV3_SHIFT   = 17;

	localparam logic [63:0] HALF_PI_Q62 = 64'h6487ED5110B4611A;

	typedef enum logic {
		OP_PAIR  = 1'b0,
		OP_CHORD = 1'b1
	} op_t;

	typedef struct packed {
		op_t              op;
		logic             left_on;
		logic             right_on;
		logic [IDX_W-1:0] idx_a;
		logic [IDX_W-1:0] idx_b;
		logic [IDX_W-1:0] idx_c;
	} cmd_t;

	typedef logic signed [SAMPLE_W-1:0] sine_rom_t [TABLE_SIZE];

	function automatic logic [63:0] mul_q62(input logic [63:0] a, input logic [63:0] b);
		logic [127:0] p;
		p = {64'd0, a} * {64'd0, b};
		return p[125:62];
	endfunction

	function automatic logic [SAMPLE_W-1:0] quarter_value(input int j);
		logic [63:0]  x;
		logic [63:0]  x2;
		logic [63:0]  term;
		logic [63:0]  sum;
		logic [127:0] p;
		if (j == 0)
			return '0;
		if (j >= QUARTER)
			return SAMPLE_W'(32767);
		x = (HALF_PI_Q62 / QUARTER) * 64'(j) + ((HALF_PI_Q62 % QUARTER) * 64'(j)) / QUARTER;
		x2 = mul_q62(x, x);
		term = x;
		sum = x;
		// sine series through the x^25 term
		term = mul_q62(term, x2) / 64'd6;
		sum  = sum - term;
		term = mul_q62(term, x2) / 64'd20;
		sum  = sum + term;
		term = mul_q62(term, x2) / 64'd42;
		sum  = sum - term;
		term = mul_q62(term, x2) / 64'd72;
		sum  = sum + term;
		term = mul_q62(term, x2) / 64'd110;
		sum  = sum - term;
		term = mul_q62(term, x2) / 64'd156;
		sum  = sum + term;
		term = mul_q62(term, x2) / 64'd210;
		sum  = sum - term;
		term = mul_q62(term, x2) / 64'd272;
		sum  = sum + term;
		term = mul_q62(term, x2) / 64'd342;
		sum  = sum - term;
		term = mul_q62(term, x2) / 64'd420;
		sum  = sum + term;
		term = mul_q62(term, x2) / 64'd506;
		sum  = sum - term;
		term = mul_q62(term, x2) / 64'd600;
		sum  = sum + term;
		p = {64'd0, sum} * 128'd32767;
		return SAMPLE_W'(p[125:62]);
	endfunction

	function automatic sine_rom_t build_rom();
		sine_rom_t          rom;
		int                 q;
		int                 j;
		logic [SAMPLE_W-1:0] m;
		for (int i = 0; i < TABLE_SIZE; i++) begin
			q = i / QUARTER;
			j = i % QUARTER;
			m = (q % 2 == 1) ? quarter_value(QUARTER - j) : quarter_value(j);
			rom[i] = (q >= 2) ? -m : m;
		end
		return rom;
	endfunction

	localparam sine_rom_t SINE_ROM = build_rom();

endpackage

// ===== design/multimode_dds_test_tone_generator_core.sv =====
// Top level of the multimode DDS test tone generator.
// Depends on mmdds_pkg, mmdds_front, mmdds_cmd_fifo and mmdds_back.
//
//   channel   handshake         payload
//   input     push / full       tick
//   result    empty / pop       left_word, right_word
//   config    cfg_we            cfg_addr, cfg_wdata
//
// One tick is taken per cycle unless full; the front end advances active oscillators in that
// cycle. The pipeline reads the sine table three times in parallel, so chords also run at one
// word per cycle unless stalled. A word passes through registers s1, s2 and s3 into the result
// queue. Reset restores control and oscillator defaults only; the sine table is constant. A
// stalled result side fills the result queue and then the command queue before full rises.
module multimode_dds_test_tone_generator_core import mmdds_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  logic              tick,
	input  logic              cfg_we,
	input  logic [CFG_AW-1:0] cfg_addr,
	input  logic [CFG_DW-1:0] cfg_wdata,
	output logic              empty,
	input  logic              pop,
	output logic [WORD_W-1:0] left_word,
	output logic [WORD_W-1:0] right_word
);

	cmd_t              cmd_in, cmd_out;
	logic              cmd_push, cmd_pop, cmd_full, cmd_empty;
	logic [GAIN_W-1:0] gain;

	assign full = cmd_full;

	mmdds_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.tick      (tick),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.cmd_full  (cmd_full),
		.cmd_push  (cmd_push),
		.cmd       (cmd_in),
		.gain      (gain)
	);

	mmdds_cmd_fifo u_cmd_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (cmd_push),
		.wr_data (cmd_in),
		.full    (cmd_full),
		.rd_en   (cmd_pop),
		.rd_data (cmd_out),
		.empty   (cmd_empty)
	);

	mmdds_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd_empty  (cmd_empty),
		.cmd        (cmd_out),
		.cmd_pop    (cmd_pop),
		.gain       (gain),
		.pop        (pop),
		.empty      (empty),
		.left_word  (left_word),
		.right_word (right_word)
	);

endmodule

// ===== design/mmdds_front.sv =====
// Front end: configuration registers, oscillator state and tick classification.
// Depends on mmdds_pkg; emits one command word per tick into the command queue.
module mmdds_front import mmdds_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  logic              tick,
	input  logic              cfg_we,
	input  logic [CFG_AW-1:0] cfg_addr,
	input  logic [CFG_DW-1:0] cfg_wdata,
	input  logic              cmd_full,
	output logic              cmd_push,
	output cmd_t              cmd,
	output logic [GAIN_W-1:0] gain
);

	logic [MODE_W-1:0]  mode_q;
	logic [GAIN_W-1:0]  gain_q;
	logic [TONE_W-1:0]  tone_q;
	logic [PHASE_W-1:0] phase_l_q, phase_r_q, chord_a_q, chord_b_q, chord_c_q;
	logic [PHASE_W-1:0] phase_l_n, phase_r_n, chord_a_n, chord_b_n, chord_c_n;
	logic [PAN_W-1:0]   pan_cnt_q, pan_cnt_n, pan_inc;
	logic               left_turn_q, left_turn_n;
	logic [SWEEP_W-1:0] sweep_q, sweep_n, sweep_bump;
	logic [SWEEP_W+SWEEP_MUL_W-1:0] sweep_prod;
	logic [PHASE_W-1:0] sweep_inc;

	assign cmd_push = push & ~cmd_full & tick;
	assign gain     = gain_q;

	assign sweep_prod = (SWEEP_W+SWEEP_MUL_W)'(sweep_q) * (SWEEP_W+SWEEP_MUL_W)'(SWEEP_MUL);
	assign sweep_bump = sweep_q + SWEEP_W'(sweep_prod >> SWEEP_SHIFT);
	assign pan_inc    = pan_cnt_q + PAN_W'(1);

	always_comb begin
		phase_l_n   = phase_l_q;
		phase_r_n   = phase_r_q;
		chord_a_n   = chord_a_q;
		chord_b_n   = chord_b_q;
		chord_c_n   = chord_c_q;
		pan_cnt_n   = pan_cnt_q;
		left_turn_n = left_turn_q;
		sweep_n     = sweep_q;
		sweep_inc   = '0;
		cmd         = '{op: OP_PAIR, left_on: 1'b0, right_on: 1'b0,
			idx_a: '0, idx_b: '0, idx_c: '0};
		case (mode_q)
			MODE_TONE: begin
				phase_l_n = phase_l_q + PHASE_W'(tone_q);
				phase_r_n = phase_r_q + PHASE_W'(tone_q);
				cmd.left_on  = 1'b1;
				cmd.right_on = 1'b1;
			end
			MODE_ALT: begin
				pan_cnt_n = pan_inc;
				if (pan_inc >= PAN_W'(PAN_PERIOD)) begin
					pan_cnt_n   = '0;
					left_turn_n = ~left_turn_q;
				end
				if (left_turn_n) begin
					phase_l_n = phase_l_q + STEP_A4;
					cmd.left_on = 1'b1;
				end else begin
					phase_r_n = phase_r_q + STEP_A5;
					cmd.right_on = 1'b1;
				end
			end
			MODE_SWEEP: begin
				sweep_n   = (sweep_bump > SWEEP_LIMIT) ? SWEEP_START : sweep_bump;
				sweep_inc = PHASE_W'(sweep_n >> FRAC_W);
				phase_l_n = phase_l_q + sweep_inc;
				phase_r_n = phase_r_q + sweep_inc;
				cmd.left_on  = 1'b1;
				cmd.right_on = 1'b1;
			end
			MODE_CHORD: begin
				chord_a_n = chord_a_q + STEP_A4;
				chord_b_n = chord_b_q + STEP_CS5;
				chord_c_n = chord_c_q + STEP_E5;
				cmd.op    = OP_CHORD;
			end
			default: begin
			end
		endcase
		if (mode_q == MODE_CHORD) begin
			cmd.idx_a = chord_a_n[PHASE_W-1:FRAC_W];
			cmd.idx_b = chord_b_n[PHASE_W-1:FRAC_W];
			cmd.idx_c = chord_c_n[PHASE_W-1:FRAC_W];
		end else if (mode_q == MODE_SWEEP) begin
			cmd.idx_a = phase_l_n[PHASE_W-1:FRAC_W];
			cmd.idx_b = phase_l_n[PHASE_W-1:FRAC_W];
		end else begin
			cmd.idx_a = phase_l_n[PHASE_W-1:FRAC_W];
			cmd.idx_b = phase_r_n[PHASE_W-1:FRAC_W];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= MODE_TONE;
			gain_q      <= GAIN_W'(2097);
			tone_q      <= TONE_W'(349525);
			phase_l_q   <= '0;
			phase_r_q   <= '0;
			chord_a_q   <= '0;
			chord_b_q   <= '0;
			chord_c_q   <= '0;
			pan_cnt_q   <= '0;
			left_turn_q <= 1'b1;
			sweep_q     <= SWEEP_START;
		end else begin
			if (cmd_push) begin
				phase_l_q   <= phase_l_n;
				phase_r_q   <= phase_r_n;
				chord_a_q   <= chord_a_n;
				chord_b_q   <= chord_b_n;
				chord_c_q   <= chord_c_n;
				pan_cnt_q   <= pan_cnt_n;
				left_turn_q <= left_turn_n;
			end
			if (cfg_we && cfg_addr == REG_MODE)
				sweep_q <= SWEEP_START;
			else if (cmd_push)
				sweep_q <= sweep_n;
			if (cfg_we) begin
				case (cfg_addr)
					REG_MODE: mode_q <= cfg_wdata[MODE_W-1:0];
					REG_GAIN: gain_q <= cfg_wdata[GAIN_W-1:0];
					REG_TONE: tone_q <= cfg_wdata[TONE_W-1:0];
					default: begin
					end
				endcase
			end
		end
	end

endmodule

// ===== design/mmdds_cmd_fifo.sv =====
// Short command queue between the front end and the sample pipeline.
// Depends on mmdds_pkg for cmd_t and the queue depth.
module mmdds_cmd_fifo import mmdds_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic wr_en,
	input  cmd_t wr_data,
	output logic full,
	input  logic rd_en,
	output cmd_t rd_data,
	output logic empty
);

	localparam int PW = $clog2(CMD_DEPTH);
	localparam int CW = $clog2(CMD_DEPTH + 1);

	cmd_t          mem_q [CMD_DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_wr, do_rd;

	assign full    = (count_q == CW'(CMD_DEPTH));
	assign empty   = (count_q == '0);
	assign rd_data = mem_q[rd_ptr_q];
	assign do_wr   = wr_en & ~full;
	assign do_rd   = rd_en & ~empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr)
				wr_ptr_q <= (wr_ptr_q == PW'(CMD_DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			if (do_rd)
				rd_ptr_q <= (rd_ptr_q == PW'(CMD_DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			count_q <= count_q + CW'(do_wr) - CW'(do_rd);
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr)
			mem_q[wr_ptr_q] <= wr_data;
	end

endmodule

// ===== design/mmdds_back.sv =====
// Sample pipeline: sine lookup and mix, chord divide by three, gain, I2S packing, result queue.
// Depends on mmdds_pkg for the sine table, cmd_t and widths.
module mmdds_back import mmdds_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cmd_empty,
	input  cmd_t              cmd,
	output logic              cmd_pop,
	input  logic [GAIN_W-1:0] gain,
	input  logic              pop,
	output logic              empty,
	output logic [WORD_W-1:0] left_word,
	output logic [WORD_W-1:0] right_word
);

	localparam int PW = $clog2(OUT_DEPTH);
	localparam int CW = $clog2(OUT_DEPTH + 1);
	localparam int PROD_W = SAMPLE_W + GAIN_W;

	logic                       valid_s1, valid_s2, valid_s3;
	logic                       chord_s1;
	logic signed [MIX_W-1:0]    left_s1;
	logic signed [SAMPLE_W-1:0] right_s1;
	logic signed [SAMPLE_W-1:0] left_s2, right_s2;
	logic [WORD_W-1:0]          left_s3, right_s3;

	logic signed [SAMPLE_W-1:0] rom_a, rom_b, rom_c;
	logic signed [MIX_W-1:0]    mix;
	logic [MIX_W-1:0]           mix_mag;
	logic [MIX_W+DIV3_RECIP_W-1:0] third_prod;
	logic [SAMPLE_W-1:0]        third_mag;
	logic signed [SAMPLE_W-1:0] third;
	logic [GAIN_W-1:0]          gain_eff;
	logic [SAMPLE_W-1:0]        mag_l, mag_r, scl_l, scl_r, smp_l, smp_r;
	logic [PROD_W-1:0]          prod_l, prod_r;

	logic [2*WORD_W-1:0] out_mem_q [OUT_DEPTH];
	logic [PW-1:0]       wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]       count_q, inflight_q;
	logic                out_pop;

	// admit a command only when the result queue has room for everything in flight
	assign cmd_pop = ~cmd_empty & (inflight_q < CW'(OUT_DEPTH));
	assign out_pop = pop & ~empty;
	assign empty   = (count_q == '0);
	assign {left_word, right_word} = out_mem_q[rd_ptr_q];

	assign rom_a = SINE_ROM[cmd.idx_a];
	assign rom_b = SINE_ROM[cmd.idx_b];
	assign rom_c = SINE_ROM[cmd.idx_c];
	assign mix   = MIX_W'(rom_a) + MIX_W'(rom_b) + MIX_W'(rom_c);

	assign mix_mag    = left_s1[MIX_W-1] ? MIX_W'(-left_s1) : MIX_W'(left_s1);
	assign third_prod = (MIX_W+DIV3_RECIP_W)'(mix_mag) * (MIX_W+DIV3_RECIP_W)'(DIV3_RECIP);
	assign third_mag  = SAMPLE_W'(third_prod >> DIV3_SHIFT);
	assign third      = left_s1[MIX_W-1] ? -third_mag : third_mag;

	assign gain_eff = (gain > UNITY_GAIN) ? UNITY_GAIN : gain;
	assign mag_l    = left_s2[SAMPLE_W-1] ? -left_s2 : left_s2;
	assign mag_r    = right_s2[SAMPLE_W-1] ? -right_s2 : right_s2;
	assign prod_l   = PROD_W'(mag_l) * PROD_W'(gain_eff);
	assign prod_r   = PROD_W'(mag_r) * PROD_W'(gain_eff);
	assign scl_l    = prod_l[GAIN_FRAC +: SAMPLE_W];
	assign scl_r    = prod_r[GAIN_FRAC +: SAMPLE_W];
	assign smp_l    = left_s2[SAMPLE_W-1] ? -scl_l : scl_l;
	assign smp_r    = right_s2[SAMPLE_W-1] ? -scl_r : scl_r;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1   <= 1'b0;
			valid_s2   <= 1'b0;
			valid_s3   <= 1'b0;
			wr_ptr_q   <= '0;
			rd_ptr_q   <= '0;
			count_q    <= '0;
			inflight_q <= '0;
		end else begin
			valid_s1 <= cmd_pop;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			if (valid_s3)
				wr_ptr_q <= (wr_ptr_q == PW'(OUT_DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			if (out_pop)
				rd_ptr_q <= (rd_ptr_q == PW'(OUT_DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			count_q    <= count_q + CW'(valid_s3) - CW'(out_pop);
			inflight_q <= inflight_q + CW'(cmd_pop) - CW'(out_pop);
		end
	end

	always_ff @(posedge clk) begin
		chord_s1 <= (cmd.op == OP_CHORD);
		if (cmd.op == OP_CHORD)
			left_s1 <= mix;
		else
			left_s1 <= cmd.left_on ? MIX_W'(rom_a) : '0;
		right_s1 <= cmd.right_on ? rom_b : '0;

		left_s2  <= chord_s1 ? third : SAMPLE_W'(left_s1);
		right_s2 <= chord_s1 ? third : right_s1;

		left_s3  <= {smp_l, WORD_LSB'(0)};
		right_s3 <= {smp_r, WORD_LSB'(0)};

		if (valid_s3)
			out_mem_q[wr_ptr_q] <= {left_s3, right_s3};
	end

endmodule
